[design/scag_pkg.sv]
// Shared types, constants and helpers for the sine/cosine activation unit.
// No dependencies; every other design file imports this package.
package scag_pkg;

	localparam int ANGLE_W   = 32;
	localparam int VALUE_W   = 32;
	localparam int RES_W     = 49;   // biased angle residue during the modulo
	localparam int ZW        = 36;   // CORDIC angle accumulator, Q.32
	localparam int XY_W      = 36;   // CORDIC x/y, Q.32
	localparam int Q_W       = 18;   // clamped Q16.16 cos/sin, [-65536, 65536]
	localparam int PROD_W    = 50;   // grad_in times derivative
	localparam int MOD_STEPS = 14;   // quotient bits of the modulo by 2pi

	localparam logic [RES_W-1:0] TWO_PI_RES = 49'd26986075409;
	// Multiple of 2pi added so the widened angle is never negative
	localparam logic [RES_W-1:0] MOD_BIAS   = TWO_PI_RES << (MOD_STEPS - 1);

	localparam logic signed [ZW-1:0] TWO_PI_Q32   = 36'sd26986075409;
	localparam logic signed [ZW-1:0] PI_Q32       = 36'sd13493037705;
	localparam logic signed [ZW-1:0] HALF_PI_Q32  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] TWO_PI_M_PI  = 36'sd13493037704;
	localparam logic signed [ZW-1:0] TWO_PI_M_HPI = 36'sd20239556557;
	localparam logic signed [XY_W-1:0] GAIN_Q32   = 36'sd2608131496;

	typedef logic signed [ZW-1:0]   zang_t;
	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Q_W-1:0]  q16_t;

	// Sideband that rides along with every item
	typedef struct packed {
		logic                      action;
		logic signed [ANGLE_W-1:0] grad_in;
	} tag_t;

	// Item in the modulo chain
	typedef struct packed {
		tag_t             tag;
		logic [RES_W-1:0] res;
	} mod_t;

	// Item in the rotation chain
	typedef struct packed {
		tag_t  tag;
		logic  neg;
		xy_t   x;
		xy_t   y;
		zang_t z;
	} rot_t;

	// atan(2^-idx) in Q.32; beyond idx 10 the value is exactly 2^(32-idx)
	function automatic zang_t atan_q32(input int unsigned idx);
		zang_t r;
		unique case (idx)
			0:       r = 36'sd3373259426;
			1:       r = 36'sd1991351318;
			2:       r = 36'sd1052175346;
			3:       r = 36'sd534100635;
			4:       r = 36'sd268086748;
			5:       r = 36'sd134174063;
			6:       r = 36'sd67103403;
			7:       r = 36'sd33553749;
			8:       r = 36'sd16777131;
			9:       r = 36'sd8388597;
			10:      r = 36'sd4194303;
			default: r = zang_t'(36'd1 << (32 - idx));
		endcase
		return r;
	endfunction

endpackage

[design/scag_if.sv]
// Valid/ready channel interfaces for the activation unit: request and response.
// Depends on scag_pkg for field widths.
interface scag_req_if;
	import scag_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic signed [ANGLE_W-1:0] angle;
	logic signed [ANGLE_W-1:0] grad_in;
	modport source (output valid, action, angle, grad_in, input ready);
	modport sink (input valid, action, angle, grad_in, output ready);
endinterface

interface scag_rsp_if;
	import scag_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

[design/scag_mod_cell.sv]
// One restoring step of the angle modulo 2pi: subtract 2pi << SHIFT if it fits.
// Depends on scag_pkg.
module scag_mod_cell #(
	parameter int SHIFT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  scag_pkg::mod_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output scag_pkg::mod_t out_data
);
	import scag_pkg::*;

	localparam logic [RES_W-1:0] SUB = TWO_PI_RES << SHIFT;

	logic         vld_q;
	mod_t         dat_q;
	mod_t         nxt;
	logic [RES_W:0] diff;

	always_comb begin
		diff = {1'b0, in_data.res} - {1'b0, SUB};
		nxt  = in_data;
		if (!diff[RES_W]) begin
			nxt.res = diff[RES_W-1:0];
		end
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dat_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;
endmodule

[design/scag_rot_cell.sv]
// One CORDIC rotation cell: micro-rotation by +/- atan(2^-STAGE), sign of z steers.
// Depends on scag_pkg.
module scag_rot_cell #(
	parameter int STAGE = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  scag_pkg::rot_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output scag_pkg::rot_t out_data
);
	import scag_pkg::*;

	localparam zang_t ATAN = atan_q32(STAGE);

	logic vld_q;
	rot_t dat_q;
	rot_t nxt;
	xy_t  xs;
	xy_t  ys;

	always_comb begin
		xs  = in_data.x >>> STAGE;
		ys  = in_data.y >>> STAGE;
		nxt = in_data;
		if (!in_data.z[ZW-1]) begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ATAN;
		end else begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ATAN;
		end
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dat_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;
endmodule

[design/scag_out_stage.sv]
// Back end: quadrant sign fix, Q16.16 round and clamp, function select,
// gradient product and saturation; last register drives the response channel.
// Depends on scag_pkg and scag_if.
module scag_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fsel,
	input  logic           in_valid,
	output logic           in_ready,
	input  scag_pkg::rot_t in_data,
	scag_rsp_if.source     rsp
);
	import scag_pkg::*;

	function automatic q16_t q16_round(input xy_t v);
		logic signed [XY_W:0]    t;
		logic signed [XY_W-16:0] q;
		q16_t                    r;
		t = $signed({v[XY_W-1], v}) + $signed((XY_W + 1)'(32768));
		q = t[XY_W:16];
		if (q > (XY_W - 15)'(65536)) begin
			r = q16_t'(65536);
		end else if (q < -(XY_W - 15)'(65536)) begin
			r = -q16_t'(65536);
		end else begin
			r = q16_t'(q);
		end
		return r;
	endfunction

	// stage 1: sign fix
	logic vld_s1;
	tag_t tag_s1;
	xy_t  x_s1;
	xy_t  y_s1;
	// stage 2: rounded value and derivative
	logic vld_s2;
	tag_t tag_s2;
	q16_t f_s2;
	q16_t d_s2;
	// stage 3: product
	logic                      vld_s3;
	logic                      act_s3;
	q16_t                      f_s3;
	logic signed [PROD_W-1:0]  prod_s3;
	// stage 4: result register
	logic                      vld_s4;
	logic signed [VALUE_W-1:0] value_s4;

	logic rdy1, rdy2, rdy3, rdy4;
	q16_t c_rnd, s_rnd;
	logic signed [PROD_W:0]     rnd;
	logic signed [PROD_W-16:0]  shr;
	logic signed [VALUE_W-1:0]  res;

	assign rdy4     = !vld_s4 || rsp.ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	assign c_rnd = q16_round(x_s1);
	assign s_rnd = q16_round(y_s1);

	always_comb begin
		rnd = $signed({prod_s3[PROD_W-1], prod_s3}) + $signed((PROD_W + 1)'(32768));
		shr = rnd[PROD_W:16];
		if (!act_s3) begin
			res = VALUE_W'(f_s3);
		end else if (shr > $signed((PROD_W - 15)'(32'h7FFF_FFFF))) begin
			res = {1'b0, {(VALUE_W - 1){1'b1}}};
		end else if (shr < -$signed((PROD_W - 15)'(32'h8000_0000))) begin
			res = {1'b1, {(VALUE_W - 1){1'b0}}};
		end else begin
			res = VALUE_W'(shr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			tag_s1 <= in_data.tag;
			x_s1   <= in_data.neg ? -in_data.x : in_data.x;
			y_s1   <= in_data.neg ? -in_data.y : in_data.y;
		end
		if (vld_s1 && rdy2) begin
			tag_s2 <= tag_s1;
			// cosine: f = cos, f' = -sin; sine: f = sin, f' = cos
			f_s2   <= fsel ? s_rnd : c_rnd;
			d_s2   <= fsel ? c_rnd : -s_rnd;
		end
		if (vld_s2 && rdy3) begin
			act_s3  <= tag_s2.action;
			f_s3    <= f_s2;
			prod_s3 <= tag_s2.grad_in * d_s2;
		end
		if (vld_s3 && rdy4) begin
			value_s4 <= res;
		end
	end

	assign rsp.valid = vld_s4;
	assign rsp.value = value_s4;
endmodule

[design/sine_cosine_activation_with_gradient_top.sv]
// Top level of the sine/cosine activation unit with gradient.
// Depends on scag_pkg, scag_if, scag_mod_cell, scag_rot_cell, scag_out_stage.
//
// Element-wise trig activation in Q16.16. function_select (APB register at
// address 0, bit 0) picks cosine (0) or sine (1). A forward item (action 0)
// returns f(angle); a backward item (action 1) returns grad_in * f'(angle),
// rounded half up and saturated to 32 bits. Cos and sin are clamped to
// [-1.0, 1.0] in Q16.16. The datapath is a chain of pipeline cells: one
// capture cell, 14 compare-subtract cells reducing the angle modulo 2pi,
// one quadrant-fold cell, CORDIC_STAGES rotation cells, then four back-end
// stages (sign fix, round/select, multiply, saturate + output register).
// Every cell has its own valid bit and takes a new item whenever it is empty
// or its successor takes its item, so the unit accepts one item per clock while
// the response channel does not stall, and bubbles collapse under backpressure.
// Only write function_select while no items are in flight.
module sine_cosine_activation_with_gradient_top #(
	parameter int CORDIC_STAGES = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channels
	scag_req_if.sink    req,
	scag_rsp_if.source  rsp
);
	import scag_pkg::*;

	// ---------------- configuration register ----------------
	logic fsel_q;
	logic reg_hit;

	// register index is paddr[2]; only index 0 exists
	assign reg_hit = !paddr[2];
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {31'd0, fsel_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			fsel_q <= pwdata[0];
		end
	end

	// ---------------- capture cell ----------------
	// Widen angle to Q.32 and add a multiple of 2pi so the residue is positive.
	logic cap_vld_s1;
	mod_t cap_s1;
	mod_t cap_nxt;

	mod_t mod_d [MOD_STEPS+1];
	logic mod_v [MOD_STEPS+1];
	logic mod_r [MOD_STEPS+1];

	always_comb begin
		cap_nxt.tag.action  = req.action;
		cap_nxt.tag.grad_in = req.grad_in;
		cap_nxt.res = RES_W'({{(RES_W - ANGLE_W - 16){req.angle[ANGLE_W-1]}},
			req.angle, 16'd0}) + MOD_BIAS;
	end

	assign req.ready = !cap_vld_s1 || mod_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_s1 <= 1'b0;
		end else if (req.ready) begin
			cap_vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cap_s1 <= cap_nxt;
		end
	end

	assign mod_d[0] = cap_s1;
	assign mod_v[0] = cap_vld_s1;

	// ---------------- modulo chain: quotient bit 13 down to 0 ----------------
	for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
		scag_mod_cell #(.SHIFT(MOD_STEPS - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (mod_v[k]),
			.in_ready  (mod_r[k]),
			.in_data   (mod_d[k]),
			.out_valid (mod_v[k+1]),
			.out_ready (mod_r[k+1]),
			.out_data  (mod_d[k+1])
		);
	end

	// ---------------- quadrant fold cell ----------------
	// Residue is in [0, 2pi). Map to [-pi/2, pi/2]; a pi shift flips both outputs.
	rot_t rot_d [CORDIC_STAGES+1];
	logic rot_v [CORDIC_STAGES+1];
	logic rot_r [CORDIC_STAGES+1];

	logic  fold_vld_s2;
	rot_t  fold_s2;
	rot_t  fold_nxt;
	zang_t zin;

	always_comb begin
		zin          = zang_t'({1'b0, mod_d[MOD_STEPS].res[ZW-2:0]});
		fold_nxt.tag = mod_d[MOD_STEPS].tag;
		fold_nxt.x   = GAIN_Q32;
		fold_nxt.y   = '0;
		if (zin <= HALF_PI_Q32) begin
			fold_nxt.z   = zin;
			fold_nxt.neg = 1'b0;
		end else if (zin <= PI_Q32) begin
			fold_nxt.z   = zin - PI_Q32;
			fold_nxt.neg = 1'b1;
		end else if (zin < TWO_PI_M_HPI) begin
			// wrapped below -pi/2: (z - 2pi) + pi
			fold_nxt.z   = zin - TWO_PI_M_PI;
			fold_nxt.neg = 1'b1;
		end else begin
			fold_nxt.z   = zin - TWO_PI_Q32;
			fold_nxt.neg = 1'b0;
		end
	end

	assign mod_r[MOD_STEPS] = !fold_vld_s2 || rot_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_vld_s2 <= 1'b0;
		end else if (mod_r[MOD_STEPS]) begin
			fold_vld_s2 <= mod_v[MOD_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (mod_v[MOD_STEPS] && mod_r[MOD_STEPS]) begin
			fold_s2 <= fold_nxt;
		end
	end

	assign rot_d[0] = fold_s2;
	assign rot_v[0] = fold_vld_s2;

	// ---------------- CORDIC rotation chain ----------------
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		scag_rot_cell #(.STAGE(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (rot_v[k]),
			.in_ready  (rot_r[k]),
			.in_data   (rot_d[k]),
			.out_valid (rot_v[k+1]),
			.out_ready (rot_r[k+1]),
			.out_data  (rot_d[k+1])
		);
	end

	// ---------------- back end ----------------
	scag_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fsel     (fsel_q),
		.in_valid (rot_v[CORDIC_STAGES]),
		.in_ready (rot_r[CORDIC_STAGES]),
		.in_data  (rot_d[CORDIC_STAGES]),
		.rsp      (rsp)
	);
endmodule

[verif/scag_tb_pkg.sv]
`timescale 1ns / 1ps
// Codes and fixed-point constants shared by the activation unit's testbench.
// No dependencies; imported by the checker and the testbench top.
package scag_tb_pkg;

	typedef enum logic {FUNC_COS = 1'b0, FUNC_SIN = 1'b1} func_sel_e;
	typedef enum logic {ACT_FORWARD = 1'b0, ACT_BACKWARD = 1'b1} action_e;

	// APB byte addresses; only function_select exists
	localparam logic [2:0] REG_FUNCTION_SELECT = 3'd0;
	localparam logic [2:0] REG_UNMAPPED        = 3'd4;

	// Q.32 angle constants
	localparam longint TWO_PI_FX      = 64'sd26986075409;
	localparam longint PI_FX          = 64'sd13493037705;
	localparam longint HALF_PI_FX     = 64'sd6746518852;
	localparam longint QUARTER_PI_FX  = 64'sd3373259426;
	localparam longint CORDIC_GAIN_FX = 64'sd2608131496;

endpackage

[verif/trig_activation_monitor.sv]
`timescale 1ns / 1ps
// Watches the APB port and both item channels, predicts each result and compares.
// Depends on scag_tb_pkg.
module trig_activation_monitor #(
	parameter int STAGES = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic        req_action,
	input  logic signed [31:0] req_angle,
	input  logic signed [31:0] req_grad_in,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic signed [31:0] rsp_value,
	output int          in_flight,
	output int          errors
);
	import scag_tb_pkg::*;

	func_sel_e          fsel_copy;
	logic signed [31:0] expected_values[$];
	int                 mismatch_count = 0;

	assign errors = mismatch_count;

	// atan(2^-i) in Q.32: Taylor series in Q.60, terms truncated, then rounded
	function automatic longint arctan_step(int i);
		longint acc, term;
		int k, e;
		if (i == 0)
			return QUARTER_PI_FX;
		acc = 0;
		for (k = 0; i * (2 * k + 1) <= 60; k++) begin
			e = i * (2 * k + 1);
			term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
			if (k % 2)
				acc -= term;
			else
				acc += term;
		end
		return (acc + (longint'(1) << 27)) >>> 28;
	endfunction

	function automatic longint q16_clamp(longint v);
		longint q;
		q = (v + 32768) >>> 16;
		if (q > 65536)
			q = 65536;
		if (q < -65536)
			q = -65536;
		return q;
	endfunction

	function automatic logic signed [31:0] trig_activation(func_sel_e fsel, action_e act,
			logic signed [31:0] angle, logic signed [31:0] grad);
		longint z, x, y, xs, ys, c, s, f, d, r;
		bit flip;
		flip = 1'b0;
		z = (longint'(angle) * 65536) % TWO_PI_FX;
		if (z < 0)
			z += TWO_PI_FX;
		if (z > PI_FX)
			z -= TWO_PI_FX;
		if (z > HALF_PI_FX) begin
			z -= PI_FX;
			flip = 1'b1;
		end else if (z < -HALF_PI_FX) begin
			z += PI_FX;
			flip = 1'b1;
		end
		x = CORDIC_GAIN_FX;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= arctan_step(i);
			end else begin
				x += ys;
				y -= xs;
				z += arctan_step(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = q16_clamp(x);
		s = q16_clamp(y);
		if (fsel == FUNC_COS) begin
			f = c;
			d = -s;
		end else begin
			f = s;
			d = c;
		end
		if (act == ACT_FORWARD) begin
			r = f;
		end else begin
			r = (longint'(grad) * d + 32768) >>> 16;
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			if (r < -64'sd2147483648)
				r = -64'sd2147483648;
		end
		return r[31:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] want;
		if (!arst_n) begin
			fsel_copy <= FUNC_COS;
			in_flight <= 0;
		end else begin
			if (psel && penable && pready && paddr == REG_FUNCTION_SELECT) begin
				if (pwrite)
					fsel_copy <= func_sel_e'(pwdata[0]);
				else if (prdata !== 32'(fsel_copy))
					report_mismatch($sformatf("function_select read %h, want %h",
						prdata, 32'(fsel_copy)));
			end
			// Results trail their items by the pipeline depth, so pop before push
			if (rsp_valid && rsp_ready) begin
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("unexpected result value=%h", rsp_value));
				end else begin
					want = expected_values.pop_front();
					if (rsp_value !== want)
						report_mismatch($sformatf("value %h, want %h", rsp_value, want));
				end
			end
			if (req_valid && req_ready)
				expected_values.push_back(trig_activation(fsel_copy,
					action_e'(req_action), req_angle, req_grad_in));
			in_flight <= expected_values.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the sine/cosine activation unit: clock, reset, APB and item stimulus.
// Depends on scag_tb_pkg, trig_activation_monitor, the design package and interfaces.
module testbench;
	import scag_tb_pkg::*;

	localparam int STAGES          = 18;
	localparam int LATENCY         = STAGES + 20;   // acceptance to result
	localparam int ITEMS_PER_PHASE = 172;
	localparam int HOLD_CYCLES     = 150;           // long enough to back up the whole pipe

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          in_flight, errors;

	// Idle mix per phase: no idling, sender gaps, receiver stalls, both
	int tx_mix[4] = '{0, 47, 0, 24};
	int rx_mix[4] = '{0, 0, 47, 24};
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;

	// Long receiver hold-off: stimulus flips hold_toggle, the receiver counts it out
	bit hold_toggle = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	scag_req_if req ();
	scag_rsp_if rsp ();

	sine_cosine_activation_with_gradient_top #(.CORDIC_STAGES(STAGES)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	trig_activation_monitor #(.STAGES(STAGES)) u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_action  (req.action),
		.req_angle   (req.angle),
		.req_grad_in (req.grad_in),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_value   (rsp.value),
		.in_flight   (in_flight),
		.errors      (errors)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls at the phase's rate, or a forced hold-off
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Setup cycle then access cycle; an idle cycle after so psel never
	// gets two assignments in one step when writes come back to back
	task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Write the select, then read it back so the monitor sees the register
	task automatic select_function(func_sel_e fsel);
		apb_access(1'b1, REG_FUNCTION_SELECT, 32'(fsel));
		apb_access(1'b0, REG_FUNCTION_SELECT, 32'd0);
	endtask

	// Offer one item, with random gaps in front at the sender's rate.
	// During gaps the payload wiggles so a stale value can't pass for a real one.
	task automatic send_item(action_e act, logic signed [31:0] ang, logic signed [31:0] grad);
		while ($urandom_range(99) < tx_gap_pct) begin
			req.valid <= 1'b0;
			req.angle <= $urandom;
			req.grad_in <= $urandom;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.angle <= ang;
		req.grad_in <= grad;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	// Mix of full-range angles, angles within one turn either side of zero, tiny angles,
	// and points right at the quadrant folds
	function automatic logic signed [31:0] pick_angle();
		int unsigned roll;
		longint k, fold;
		roll = $urandom_range(99);
		if (roll < 30)
			return $urandom;
		if (roll < 65)
			return int'($urandom_range(0, 823550)) - 411775;
		if (roll < 75)
			return int'($urandom_range(0, 4000)) - 2000;
		k = longint'($urandom_range(0, 40)) - 20;
		fold = (k * HALF_PI_FX) >>> 16;
		return 32'(fold + longint'($urandom_range(0, 6)) - 3);
	endfunction

	function automatic logic signed [31:0] pick_grad();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return $urandom;
		if (roll < 80)
			return int'($urandom_range(0, 524288)) - 262144;
		case ($urandom_range(4))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd65536;
		endcase
	endfunction

	// Directed angles: zero, +/- one lsb, field extremes, both sides of pi and
	// pi/2, one full turn; each goes out forward and backward
	logic signed [31:0] dir_angle[12] = '{0, 1, -1, 32'h7fff_ffff, 32'h8000_0000,
		205887, 205888, -205888, 102943, 102944, -102944, 411775};
	logic signed [31:0] dir_grad[12] = '{32'h7fff_ffff, 32'h8000_0000, 65536, -65536, 1,
		-1, 32'h8000_0000, 32'h7fff_ffff, 12345, 32768, -32768, 3};

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.action = 1'b0;
		req.angle = '0;
		req.grad_in = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass with the reset select (cosine)
		for (int i = 0; i < 12; i++) begin
			send_item(ACT_FORWARD, dir_angle[i], dir_grad[i]);
			send_item(ACT_BACKWARD, dir_angle[i], dir_grad[i]);
		end
		drain();

		// A write outside the register map must leave the select alone
		apb_access(1'b1, REG_UNMAPPED, 32'hffff_ffff);
		apb_access(1'b0, REG_FUNCTION_SELECT, 32'd0);

		// Random phases: every idle mix, each function in turn
		for (int p = 0; p < 8; p++) begin
			tx_gap_pct = tx_mix[p % 4];
			rx_stall_pct = rx_mix[p % 4];
			select_function(func_sel_e'((p + p / 4) % 2));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// back the pipe up while the sender keeps pushing
				if (p == 0 && n == 20)
					hold_toggle <= ~hold_toggle;
				// sender pause until the pipe runs dry
				if (p == 2 && n == 85)
					drain();
				send_item(action_e'($urandom_range(1)), pick_angle(), pick_grad());
			end
			drain();
		end

		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("sine_cosine_activation_with_gradient_top: match");
		else
			$display("sine_cosine_activation_with_gradient_top: mismatch");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this
	initial begin
		#2_000_000;
		$display("sine_cosine_activation_with_gradient_top: mismatch");
		$finish;
	end

endmodule
